// ===== sv/kts_pkg.sv =====
// Shared types and constants for the keyframe track sampler.
`default_nettype none
package kts_pkg;

    localparam int KEYS_DEF      = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_W         = 24;
    localparam int STEP_W        = 5;
    localparam int CFG_AW        = 5;

    localparam logic [2:0] REG_KEY_COUNT   = 3'd0;
    localparam logic [2:0] REG_INTERPOLATE = 3'd1;
    localparam logic [2:0] REG_TRACK_KIND  = 3'd2;
    localparam logic [2:0] REG_START_STATE = 3'd3;
    localparam logic [2:0] REG_NUM_FRAMES  = 3'd4;
    localparam logic [2:0] REG_CYCLIC      = 3'd5;

    localparam logic [1:0] KIND_SCALAR   = 2'd0;
    localparam logic [1:0] KIND_COLOUR   = 2'd1;
    localparam logic [1:0] KIND_TOGGLE   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic       REQ_LOAD   = 1'b0;
    localparam logic       REQ_SAMPLE = 1'b1;

    localparam logic [31:0] EMPTY_COLOUR = 32'hFFFF_FFFF;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;

    typedef struct packed {
        logic [6:0]  key_count;
        logic        interpolate_on;
        logic [1:0]  track_kind;
        logic        start_state;
        logic [22:0] num_frames;
        logic        cyclic;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRAP,
        S_WRAP_WAIT,
        S_DISPATCH,
        S_TOG_RD,
        S_TOG,
        S_K0_RD,
        S_K0,
        S_KL_RD,
        S_KL,
        S_SCAN_RD,
        S_SCAN,
        S_DIV_WAIT,
        S_VA_RD,
        S_VA,
        S_VB_RD,
        S_VB,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== sv/kts_cfg_regs.sv =====
// APB configuration registers of the keyframe track sampler.
`default_nettype none
module kts_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kts_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output kts_pkg::cfg_t                   cfg
);

    kts_pkg::cfg_t cfg_reg;
    kts_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                kts_pkg::REG_KEY_COUNT:   cfg_next.key_count      = pwdata[6:0];
                kts_pkg::REG_INTERPOLATE: cfg_next.interpolate_on = pwdata[0];
                kts_pkg::REG_TRACK_KIND:  cfg_next.track_kind     = pwdata[1:0];
                kts_pkg::REG_START_STATE: cfg_next.start_state    = pwdata[0];
                kts_pkg::REG_NUM_FRAMES:  cfg_next.num_frames     = pwdata[22:0];
                kts_pkg::REG_CYCLIC:      cfg_next.cyclic         = pwdata[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            kts_pkg::REG_KEY_COUNT:   prdata = {25'd0, cfg_reg.key_count};
            kts_pkg::REG_INTERPOLATE: prdata = {31'd0, cfg_reg.interpolate_on};
            kts_pkg::REG_TRACK_KIND:  prdata = {30'd0, cfg_reg.track_kind};
            kts_pkg::REG_START_STATE: prdata = {31'd0, cfg_reg.start_state};
            kts_pkg::REG_NUM_FRAMES:  prdata = {9'd0, cfg_reg.num_frames};
            kts_pkg::REG_CYCLIC:      prdata = {31'd0, cfg_reg.cyclic};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                <= '0;
            cfg_reg.interpolate_on <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/kts_key_mem.sv =====
// Key store: frame and value memories with one write and one registered read port.
`default_nettype none
module kts_key_mem #(
    parameter int KEYS = kts_pkg::KEYS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [$clog2(KEYS)-1:0] waddr,
    input  wire logic [15:0]             wframe,
    input  wire logic [31:0]             wvalue,
    input  wire logic [$clog2(KEYS)-1:0] raddr,
    output logic      [15:0]             rframe,
    output logic      [31:0]             rvalue
);

    logic [15:0] frame_mem [KEYS];
    logic [31:0] value_mem [KEYS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame_mem[waddr] <= wframe;
            value_mem[waddr] <= wvalue;
        end
        rframe <= frame_mem[raddr];
        rvalue <= value_mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/kts_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by frame wrap and blend fraction.
`default_nettype none
module kts_serial_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kts_pkg::div_req_t req,
    output kts_pkg::div_rsp_t      rsp
);

    localparam int W = kts_pkg::DIV_W;

    logic [W-1:0]                 rem_reg, rem_next;
    logic [W-1:0]                 qr_reg, qr_next;
    logic [W-1:0]                 div_reg, div_next;
    logic [kts_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [W:0]                   trial;
    logic                         ge;

    assign trial = {rem_reg, qr_reg[W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        qr_next   = qr_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = req.rem_init;
            qr_next  = req.dividend;
            div_next = req.divisor;
            cnt_next = req.steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? W'(trial - {1'b0, div_reg}) : trial[W-1:0];
            qr_next   = {qr_reg[W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == kts_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qr_reg  <= qr_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qr_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// ===== sv/keyframe_track_sampler_unit.sv =====
// Top level of the keyframe track sampler: sequencer around the key store and divider.
//
//  channel  | direction | transaction
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | load one key (tuser 0) or sample the track (tuser 1)
//  m_axis   | out       | one sampled result per sample transaction
//  apb      | in/out    | configuration registers at byte address 4*i
//
//  A load of an index below KEYS is written to the key store when it is accepted.
//  A sample runs a wrap step, with a division of the frame when cyclic, a dispatch
//  step, key reads by the search (first key, last key, then the linear scan over
//  the key store's single read port), the fraction division, and then the value
//  reads, the blend and the output register.
//  Reset clears the sequencer, the divider control and the output valid.
//  A stalled result is held in the output register; the next input
//  transaction is taken while it waits.
`default_nettype none
module keyframe_track_sampler_unit #(
    parameter int KEYS      = kts_pkg::KEYS_DEF,
    parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // key_index[5:0], key_frame[21:6], key_value[53:22], sample_frame[77:54]
    input  wire logic [79:0]                s_axis_tdata,
    // req_type[0]
    input  wire logic [0:0]                 s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // sample_value[31:0], toggle_value[32], was_blended[33]
    output logic      [39:0]                m_axis_tdata,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kts_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    localparam int AW  = $clog2(KEYS);
    localparam int CW  = $clog2(KEYS + 1);
    localparam int NW  = (CW > 7) ? CW : 7;
    localparam int IW  = (AW > 6) ? AW : 6;
    localparam int PW  = 34 + FRAC_BITS;
    localparam int CPW = 10 + FRAC_BITS;
    localparam int DW  = kts_pkg::DIV_W;

    kts_pkg::cfg_t     cfg;
    kts_pkg::div_req_t dreq;
    kts_pkg::div_rsp_t drsp;
    kts_pkg::state_t   state_reg, state_next;

    logic [5:0]  in_key_index;
    logic [15:0] in_key_frame;
    logic [31:0] in_key_value;
    logic [23:0] in_sample_frame;
    logic        in_accept;
    logic        mem_we;
    logic [IW:0] idx_wide;
    logic [AW-1:0] raddr;
    logic [15:0] rframe;
    logic [31:0] rvalue;
    logic [23:0] kp;
    logic [NW-1:0] n_keys;
    logic [NW-1:0] n_last;

    logic [23:0] f_reg, f_next;
    logic        neg_reg, neg_next;
    logic [NW-1:0] i_reg, i_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic [23:0] prev_reg, prev_next;
    logic        inside_reg, inside_next;
    logic [FRAC_BITS-1:0] t_reg, t_next;
    logic [31:0] va_reg, va_next;
    logic [31:0] vb_reg, vb_next;
    logic        tog_reg, tog_next;
    logic [31:0] res_reg, res_next;
    logic        bl_reg, bl_next;
    logic [PW-1:0]  prod_reg;
    logic [CPW-1:0] cprod_reg [4];
    logic        mv_reg, mv_next;
    logic [31:0] ov_reg, ov_next;
    logic        ot_reg, ot_next;
    logic        ob_reg, ob_next;

    logic [23:0] nf24;
    logic signed [32:0]      diff_s;
    logic signed [FRAC_BITS:0] t_s;
    logic signed [PW-1:0]    prod_s;
    logic signed [PW-1:0]    step_s;
    logic [PW-1:0]           sum_w;
    logic signed [CPW-1:0]   cprod_s [4];
    logic [31:0]             colour_res;

    assign in_key_index    = s_axis_tdata[5:0];
    assign in_key_frame    = s_axis_tdata[21:6];
    assign in_key_value    = s_axis_tdata[53:22];
    assign in_sample_frame = s_axis_tdata[77:54];

    assign s_axis_tready = (state_reg == kts_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign idx_wide      = (IW + 1)'(in_key_index);
    assign mem_we        = in_accept & (s_axis_tuser[0] == kts_pkg::REQ_LOAD)
                           & (idx_wide < (IW + 1)'(KEYS));

    assign n_keys = (NW'(cfg.key_count) > NW'(KEYS)) ? NW'(KEYS) : NW'(cfg.key_count);
    assign n_last = n_keys - 1'b1;
    assign kp     = {rframe, 8'h00};
    assign nf24   = {1'b0, cfg.num_frames};

    kts_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kts_key_mem #(
        .KEYS (KEYS)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (idx_wide[AW-1:0]),
        .wframe (in_key_frame),
        .wvalue (in_key_value),
        .raddr  (raddr),
        .rframe (rframe),
        .rvalue (rvalue)
    );

    kts_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        unique case (state_reg)
            kts_pkg::S_KL_RD:   raddr = n_last[AW-1:0];
            kts_pkg::S_SCAN_RD: raddr = i_reg[AW-1:0];
            kts_pkg::S_TOG_RD:  raddr = i_reg[AW-1:0];
            kts_pkg::S_VA_RD:   raddr = a_reg;
            kts_pkg::S_VB_RD:   raddr = b_reg;
            default:            raddr = '0;
        endcase
    end

    assign diff_s = $signed({vb_reg[31], vb_reg}) - $signed({va_reg[31], va_reg});
    assign t_s    = $signed({1'b0, t_reg});
    assign prod_s = PW'(diff_s * t_s);
    assign step_s = $signed(prod_reg) >>> FRAC_BITS;
    assign sum_w  = PW'($signed({{(PW - 32){va_reg[31]}}, va_reg}) + step_s);

    for (genvar k = 0; k < 4; k++)
    begin : g_byte
        logic signed [8:0] dk;
        logic [CPW-1:0]    acc;
        assign dk         = $signed({1'b0, vb_reg[8*k +: 8]}) - $signed({1'b0, va_reg[8*k +: 8]});
        assign cprod_s[k] = CPW'(dk * t_s);
        assign acc        = CPW'({va_reg[8*k +: 8], {FRAC_BITS{1'b0}}}) + cprod_reg[k];
        assign colour_res[8*k +: 8] = acc[FRAC_BITS +: 8] & kts_pkg::BYTE_MASK;
    end

    always_comb
    begin
        state_next  = state_reg;
        f_next      = f_reg;
        neg_next    = neg_reg;
        i_next      = i_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        prev_next   = prev_reg;
        inside_next = inside_reg;
        t_next      = t_reg;
        va_next     = va_reg;
        vb_next     = vb_reg;
        tog_next    = tog_reg;
        res_next    = res_reg;
        bl_next     = bl_reg;
        mv_next     = mv_reg & ~m_axis_tready;
        ov_next     = ov_reg;
        ot_next     = ot_reg;
        ob_next     = ob_reg;
        dreq        = '0;

        unique case (state_reg)
            kts_pkg::S_IDLE:
            begin
                if (in_accept && s_axis_tuser[0] == kts_pkg::REQ_SAMPLE)
                begin
                    f_next     = in_sample_frame;
                    neg_next   = in_sample_frame[23];
                    state_next = kts_pkg::S_WRAP;
                end
            end
            kts_pkg::S_WRAP:
            begin
                if (cfg.num_frames == '0)
                begin
                    f_next     = '0;
                    state_next = kts_pkg::S_DISPATCH;
                end
                else if (cfg.cyclic)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = neg_reg ? 24'(-f_reg) : f_reg;
                    dreq.divisor  = nf24;
                    dreq.steps    = kts_pkg::STEP_W'(DW);
                    state_next    = kts_pkg::S_WRAP_WAIT;
                end
                else
                begin
                    if (neg_reg)
                        f_next = '0;
                    else if (f_reg > nf24)
                        f_next = nf24;
                    state_next = kts_pkg::S_DISPATCH;
                end
            end
            kts_pkg::S_WRAP_WAIT:
            begin
                if (drsp.done)
                begin
                    f_next     = (neg_reg && drsp.rem != '0) ? (nf24 - drsp.rem) : drsp.rem;
                    state_next = kts_pkg::S_DISPATCH;
                end
            end
            kts_pkg::S_DISPATCH:
            begin
                i_next      = '0;
                inside_next = 1'b0;
                t_next      = '0;
                bl_next     = 1'b0;
                tog_next    = cfg.start_state;
                if (cfg.track_kind == kts_pkg::KIND_TOGGLE)
                begin
                    res_next   = '0;
                    state_next = (n_keys == '0) ? kts_pkg::S_OUT : kts_pkg::S_TOG_RD;
                end
                else
                begin
                    tog_next = 1'b0;
                    if (n_keys == '0)
                    begin
                        res_next   = (cfg.track_kind == kts_pkg::KIND_COLOUR)
                                     ? kts_pkg::EMPTY_COLOUR : 32'd0;
                        state_next = kts_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = kts_pkg::S_K0_RD;
                    end
                end
            end
            kts_pkg::S_TOG_RD:
            begin
                state_next = kts_pkg::S_TOG;
            end
            kts_pkg::S_TOG:
            begin
                if (f_reg < kp)
                begin
                    state_next = kts_pkg::S_OUT;
                end
                else
                begin
                    tog_next   = ~tog_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = (i_reg == n_last) ? kts_pkg::S_OUT : kts_pkg::S_TOG_RD;
                end
            end
            kts_pkg::S_K0_RD:
            begin
                state_next = kts_pkg::S_K0;
            end
            kts_pkg::S_K0:
            begin
                prev_next = kp;
                if (f_reg <= kp)
                begin
                    a_next     = '0;
                    state_next = kts_pkg::S_VA_RD;
                end
                else
                begin
                    state_next = kts_pkg::S_KL_RD;
                end
            end
            kts_pkg::S_KL_RD:
            begin
                state_next = kts_pkg::S_KL;
            end
            kts_pkg::S_KL:
            begin
                if (f_reg >= kp)
                begin
                    a_next     = n_last[AW-1:0];
                    state_next = kts_pkg::S_VA_RD;
                end
                else
                begin
                    i_next     = NW'(1);
                    state_next = kts_pkg::S_SCAN_RD;
                end
            end
            kts_pkg::S_SCAN_RD:
            begin
                state_next = kts_pkg::S_SCAN;
            end
            kts_pkg::S_SCAN:
            begin
                if (f_reg >= kp)
                begin
                    prev_next  = kp;
                    i_next     = i_reg + 1'b1;
                    state_next = kts_pkg::S_SCAN_RD;
                end
                else
                begin
                    a_next      = AW'(i_reg - 1'b1);
                    b_next      = i_reg[AW-1:0];
                    inside_next = 1'b1;
                    if (kp > prev_reg)
                    begin
                        dreq.start    = 1'b1;
                        dreq.rem_init = f_reg - prev_reg;
                        dreq.divisor  = kp - prev_reg;
                        dreq.steps    = kts_pkg::STEP_W'(FRAC_BITS);
                        state_next    = kts_pkg::S_DIV_WAIT;
                    end
                    else
                    begin
                        t_next     = '0;
                        state_next = kts_pkg::S_VA_RD;
                    end
                end
            end
            kts_pkg::S_DIV_WAIT:
            begin
                if (drsp.done)
                begin
                    t_next     = drsp.quot[FRAC_BITS-1:0];
                    state_next = kts_pkg::S_VA_RD;
                end
            end
            kts_pkg::S_VA_RD:
            begin
                state_next = kts_pkg::S_VA;
            end
            kts_pkg::S_VA:
            begin
                va_next = rvalue;
                if (inside_reg && cfg.interpolate_on)
                begin
                    bl_next    = 1'b1;
                    state_next = kts_pkg::S_VB_RD;
                end
                else
                begin
                    res_next   = rvalue;
                    state_next = kts_pkg::S_OUT;
                end
            end
            kts_pkg::S_VB_RD:
            begin
                state_next = kts_pkg::S_VB;
            end
            kts_pkg::S_VB:
            begin
                vb_next    = rvalue;
                state_next = kts_pkg::S_MUL;
            end
            kts_pkg::S_MUL:
            begin
                state_next = kts_pkg::S_SUM;
            end
            kts_pkg::S_SUM:
            begin
                res_next   = (cfg.track_kind == kts_pkg::KIND_COLOUR) ? colour_res : sum_w[31:0];
                state_next = kts_pkg::S_OUT;
            end
            kts_pkg::S_OUT:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    mv_next    = 1'b1;
                    ov_next    = res_reg;
                    ot_next    = tog_reg;
                    ob_next    = bl_reg;
                    state_next = kts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kts_pkg::S_IDLE;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg      <= f_next;
        neg_reg    <= neg_next;
        i_reg      <= i_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        prev_reg   <= prev_next;
        inside_reg <= inside_next;
        t_reg      <= t_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        tog_reg    <= tog_next;
        res_reg    <= res_next;
        bl_reg     <= bl_next;
        ov_reg     <= ov_next;
        ot_reg     <= ot_next;
        ob_reg     <= ob_next;
        prod_reg   <= prod_s;
        for (int k = 0; k < 4; k++)
        begin
            cprod_reg[k] <= cprod_s[k];
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {6'd0, ob_reg, ot_reg, ov_reg};

endmodule
`default_nettype wire

// ===== sv/kts_checker.sv =====
// Port-level assertions for the keyframe track sampler, bound to the top level.
`default_nettype none
module kts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
        else $error("sample transaction did not occupy the sequencer");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
        else $error("load transaction stalled the input");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready) && pready)
        else $error("result appeared without a sample in progress");

endmodule

bind keyframe_track_sampler_unit kts_checker u_kts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
`default_nettype wire
